>>> rtl/core/lmc_pkg.sv
// ----------------------------------------------------------------------------
// lmc_pkg: shared types and constants of the D2Q9 collision pipeline
// Holds the fixed-point types, the forward and inverse transform matrices,
// the rate register map and the constants of the divide-by-nine step.
// ----------------------------------------------------------------------------
package lmc_pkg;

	localparam int NUM_DIRS  = 9;
	localparam int NUM_RATES = 6;
	localparam int FIELD_W   = 18;
	localparam int RATE_W    = 15;
	localparam int MOM_W     = 24;	// forward moments
	localparam int DIFF_W    = 33;	// moment minus equilibrium
	localparam int RELAX_W   = 48;	// difference times rate
	localparam int ACC_W     = 56;	// inverse transform sum
	localparam int QUO_IN_W  = 25;	// biased operand of the divide by nine
	localparam int DIV9_SHIFT = 29;
	localparam int PROD_W    = QUO_IN_W + 26;

	// ceil(2^29 / 9); exact floor division for operands below 2^27.
	localparam logic [25:0] DIV9_MULT = 26'd59652324;
	// Bias that makes the clamped quotient operand non-negative (9 * 2^20).
	localparam int DIV9_BIAS_Q = 1 << 20;

	typedef logic signed [FIELD_W-1:0] q14_t;
	typedef logic [RATE_W-1:0]         rate_t;
	typedef logic signed [RELAX_W-1:0] relax_t;
	typedef logic signed [4:0]         coef_t;

	typedef enum logic [2:0] {
		RATE_DENSITY       = 3'd0,
		RATE_ENERGY        = 3'd1,
		RATE_ENERGY_SQUARE = 3'd2,
		RATE_MOMENTUM      = 3'd3,
		RATE_HEAT_FLUX     = 3'd4,
		RATE_STRESS        = 3'd5
	} rate_idx_t;

	localparam rate_t RATE_RESET [NUM_RATES] = '{
		15'd16384, 15'd22938, 15'd22938, 15'd16384, 15'd19661, 15'd16222
	};

	localparam rate_idx_t RATE_OF_MOMENT [NUM_DIRS] = '{
		RATE_DENSITY, RATE_ENERGY, RATE_ENERGY_SQUARE, RATE_MOMENTUM, RATE_HEAT_FLUX,
		RATE_MOMENTUM, RATE_HEAT_FLUX, RATE_STRESS, RATE_STRESS
	};

	localparam coef_t FWD_MAT [NUM_DIRS][NUM_DIRS] = '{
		'{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1},
		'{-5'sd4, -5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd2,  5'sd2,  5'sd2,  5'sd2},
		'{ 5'sd4, -5'sd2, -5'sd2, -5'sd2, -5'sd2,  5'sd1,  5'sd1,  5'sd1,  5'sd1},
		'{ 5'sd0,  5'sd1,  5'sd0, -5'sd1,  5'sd0,  5'sd1, -5'sd1, -5'sd1,  5'sd1},
		'{ 5'sd0, -5'sd2,  5'sd0,  5'sd2,  5'sd0,  5'sd1, -5'sd1, -5'sd1,  5'sd1},
		'{ 5'sd0,  5'sd0,  5'sd1,  5'sd0, -5'sd1,  5'sd1,  5'sd1, -5'sd1, -5'sd1},
		'{ 5'sd0,  5'sd0, -5'sd2,  5'sd0,  5'sd2,  5'sd1,  5'sd1, -5'sd1, -5'sd1},
		'{ 5'sd0,  5'sd1, -5'sd1,  5'sd1, -5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd0},
		'{ 5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd1, -5'sd1,  5'sd1, -5'sd1}
	};

	// Inverse transform scaled by 36.
	localparam coef_t INV_MAT [NUM_DIRS][NUM_DIRS] = '{
		'{5'sd4, -5'sd4,  5'sd4,  5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0},
		'{5'sd4, -5'sd1, -5'sd2,  5'sd6, -5'sd6,  5'sd0,  5'sd0,  5'sd9,  5'sd0},
		'{5'sd4, -5'sd1, -5'sd2,  5'sd0,  5'sd0,  5'sd6, -5'sd6, -5'sd9,  5'sd0},
		'{5'sd4, -5'sd1, -5'sd2, -5'sd6,  5'sd6,  5'sd0,  5'sd0,  5'sd9,  5'sd0},
		'{5'sd4, -5'sd1, -5'sd2,  5'sd0,  5'sd0, -5'sd6,  5'sd6, -5'sd9,  5'sd0},
		'{5'sd4,  5'sd2,  5'sd1,  5'sd6,  5'sd3,  5'sd6,  5'sd3,  5'sd0,  5'sd9},
		'{5'sd4,  5'sd2,  5'sd1, -5'sd6, -5'sd3,  5'sd6,  5'sd3,  5'sd0, -5'sd9},
		'{5'sd4,  5'sd2,  5'sd1, -5'sd6, -5'sd3, -5'sd6, -5'sd3,  5'sd0,  5'sd9},
		'{5'sd4,  5'sd2,  5'sd1,  5'sd6,  5'sd3, -5'sd6, -5'sd3,  5'sd0, -5'sd9}
	};

endpackage

>>> rtl/core/lbm_d2q9_mrt_collision.sv
// ----------------------------------------------------------------------------
// lbm_d2q9_mrt_collision: D2Q9 multiple-relaxation collision for one cell
// Streaming collision operator with programmable relaxation rates.
// ----------------------------------------------------------------------------
// The block takes one lattice cell per item (nine distributions, density and
// two velocity components, all signed Q4.14) and returns one item with the
// nine post-collision distributions and a saturation flag. It accepts one
// item every clock while the output is not stalled and holds 13 items in
// flight, one per stage of the eight-stage moment front end, the four stages
// of the nine parallel direction lanes and the merging output register.
// The whole pipeline advances together, so when the downstream side stalls,
// the input side stalls with it once the output register is full. The six
// relaxation rates are unsigned Q1.14 registers written over the cfg channel,
// which is always ready; rates should only change while no item is in flight.
// ----------------------------------------------------------------------------
module lbm_d2q9_mrt_collision (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// From bit 0: f_rest, f_east, f_north, f_west, f_south, f_northeast,
	// f_northwest, f_southwest, f_southeast, density, velocity_x, velocity_y.
	input  logic [215:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// From bit 0: post_rest, post_east, post_north, post_west, post_south,
	// post_northeast, post_northwest, post_southwest, post_southeast, zero pad.
	output logic [167:0] m_axis_tdata,
	// Bit 0: saturated.
	output logic         m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [14:0]  cfg_data
);

	localparam int ND    = lmc_pkg::NUM_DIRS;
	localparam int FW    = lmc_pkg::FIELD_W;
	localparam int DEPTH = 12;	// front end plus lane stages

	logic                en;
	logic [DEPTH-1:0]    vld_q;
	logic                out_valid_q;
	logic [167:0]        out_data_q;
	logic                out_sat_q;
	lmc_pkg::rate_t      rate_q [lmc_pkg::NUM_RATES];
	lmc_pkg::q14_t       f_in [ND];
	lmc_pkg::q14_t       f_fe [ND];
	lmc_pkg::relax_t     relax [ND];
	logic signed [23:0]  post_wide [ND];
	logic [167:0]        merged;
	logic                merged_sat;

	// A single enable moves every stage; it drops only when the output
	// register holds an item that the sink is not taking.
	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lmc_pkg::NUM_RATES; i++) begin
				rate_q[i] <= lmc_pkg::RATE_RESET[i];
			end
		end else if (cfg_valid) begin
			unique case (lmc_pkg::rate_idx_t'(cfg_index))
				lmc_pkg::RATE_DENSITY:       rate_q[lmc_pkg::RATE_DENSITY]       <= cfg_data;
				lmc_pkg::RATE_ENERGY:        rate_q[lmc_pkg::RATE_ENERGY]        <= cfg_data;
				lmc_pkg::RATE_ENERGY_SQUARE: rate_q[lmc_pkg::RATE_ENERGY_SQUARE] <= cfg_data;
				lmc_pkg::RATE_MOMENTUM:      rate_q[lmc_pkg::RATE_MOMENTUM]      <= cfg_data;
				lmc_pkg::RATE_HEAT_FLUX:     rate_q[lmc_pkg::RATE_HEAT_FLUX]     <= cfg_data;
				lmc_pkg::RATE_STRESS:        rate_q[lmc_pkg::RATE_STRESS]        <= cfg_data;
				default: begin
					// Indexes past the register list are dropped.
				end
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < ND; k++) begin
			f_in[k] = s_axis_tdata[k*FW +: FW];
		end
	end

	lmc_moments u_moments (
		.clk   (clk),
		.en    (en),
		.f     (f_in),
		.rho   (s_axis_tdata[9*FW +: FW]),
		.u     (s_axis_tdata[10*FW +: FW]),
		.v     (s_axis_tdata[11*FW +: FW]),
		.rate  (rate_q),
		.relax (relax),
		.f_out (f_fe)
	);

	// One lane per direction, each applying its row of the inverse transform.
	for (genvar k = 0; k < ND; k++) begin : g_lane
		lmc_lane #(
			.LANE (k)
		) u_lane (
			.clk       (clk),
			.en        (en),
			.relax     (relax),
			.f         (f_fe[k]),
			.post_wide (post_wide[k])
		);
	end

	// Merge: clip each lane to the field range and OR the clip flags.
	always_comb begin
		merged     = '0;
		merged_sat = 1'b0;
		for (int k = 0; k < ND; k++) begin
			if (post_wide[k] > 24'sd131071) begin
				merged[k*FW +: FW] = 18'sd131071;
				merged_sat         = 1'b1;
			end else if (post_wide[k] < -24'sd131072) begin
				merged[k*FW +: FW] = -18'sd131072;
				merged_sat         = 1'b1;
			end else begin
				merged[k*FW +: FW] = post_wide[k][FW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[DEPTH-2:0], s_axis_tvalid};
			out_valid_q <= vld_q[DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= merged;
			out_sat_q  <= merged_sat;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_sat_q;

endmodule

>>> rtl/core/lmc_moments.sv
// ----------------------------------------------------------------------------
// lmc_moments: moment and equilibrium front end
// Eight pipeline stages that form m = M*f, the equilibrium moments, their
// difference and the difference scaled by its relaxation rate.
// ----------------------------------------------------------------------------
module lmc_moments (
	input  logic          clk,
	input  logic          en,
	input  lmc_pkg::q14_t f       [lmc_pkg::NUM_DIRS],
	input  lmc_pkg::q14_t rho,
	input  lmc_pkg::q14_t u,
	input  lmc_pkg::q14_t v,
	input  lmc_pkg::rate_t rate   [lmc_pkg::NUM_RATES],
	output lmc_pkg::relax_t relax [lmc_pkg::NUM_DIRS],
	output lmc_pkg::q14_t f_out   [lmc_pkg::NUM_DIRS]
);

	localparam int ND = lmc_pkg::NUM_DIRS;
	localparam int MW = lmc_pkg::MOM_W;
	localparam int DW = lmc_pkg::DIFF_W;
	localparam int RW = lmc_pkg::RELAX_W;

	lmc_pkg::q14_t f_s1 [ND], f_s2 [ND], f_s3 [ND], f_s4 [ND];
	lmc_pkg::q14_t f_s5 [ND], f_s6 [ND], f_s7 [ND], f_s8 [ND];
	logic signed [MW-1:0] m_s1 [ND], m_s2 [ND], m_s3 [ND], m_s4 [ND], m_s5 [ND], m_s6 [ND];
	lmc_pkg::q14_t rho_s1, rho_s2, rho_s3, rho_s4, rho_s5, rho_s6;
	lmc_pkg::q14_t u_s1, v_s1, u_s2, v_s2;

	logic signed [MW-1:0] m_c [ND];
	logic signed [35:0] uu_s1, vv_s1, uv_s1;
	logic [35:0]        s2_s2;
	logic signed [35:0] df_s2, uv_s2;
	logic signed [36:0] p_lo_s3, p_hi_s3, df_lo_s3, df_hi_s3, uv_lo_s3, uv_hi_s3;
	logic signed [35:0] ru_s3, rv_s3;
	logic signed [55:0] p_full, df_full, uv_full;
	logic signed [36:0] ru_rnd, rv_rnd;
	logic signed [25:0] p_s4, meq7_s4, meq8_s4, meq7_s5, meq8_s5, meq7_s6, meq8_s6;
	logic signed [22:0] meq3_s4, meq5_s4, meq3_s5, meq5_s5, meq3_s6, meq5_s6;
	logic signed [27:0] t1_s5, t2_s5;
	logic signed [45:0] e1_s6, e2_s6, e1_rnd, e2_rnd;
	logic signed [DW-1:0] d_c [ND], d_s7 [ND];
	lmc_pkg::relax_t r_s8 [ND];

	// Forward transform: constant weights, nine independent rows.
	always_comb begin
		for (int k = 0; k < ND; k++) begin
			m_c[k] = '0;
			for (int l = 0; l < ND; l++) begin
				m_c[k] = m_c[k] + MW'(f[l]) * MW'(lmc_pkg::FWD_MAT[k][l]);
			end
		end
	end

	// Stage 1: moments and velocity products.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s1   <= f;
			m_s1   <= m_c;
			rho_s1 <= rho;
			u_s1   <= u;
			v_s1   <= v;
			uu_s1  <= 36'(u) * 36'(u);
			vv_s1  <= 36'(v) * 36'(v);
			uv_s1  <= 36'(u) * 36'(v);
		end
	end

	// Stage 2: squared speed and the difference of squares.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s2   <= f_s1;
			m_s2   <= m_s1;
			rho_s2 <= rho_s1;
			u_s2   <= u_s1;
			v_s2   <= v_s1;
			s2_s2  <= 36'(unsigned'(uu_s1)) + 36'(unsigned'(vv_s1));
			df_s2  <= uu_s1 - vv_s1;
			uv_s2  <= uv_s1;
		end
	end

	// Stage 3: density products, the 36-bit operands split into 18-bit halves.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s3     <= f_s2;
			m_s3     <= m_s2;
			rho_s3   <= rho_s2;
			p_lo_s3  <= 37'(rho_s2) * 37'($signed({1'b0, s2_s2[17:0]}));
			p_hi_s3  <= 37'(rho_s2) * 37'($signed({1'b0, s2_s2[35:18]}));
			df_lo_s3 <= 37'(rho_s2) * 37'($signed({1'b0, df_s2[17:0]}));
			df_hi_s3 <= 37'(rho_s2) * 37'($signed(df_s2[35:18]));
			uv_lo_s3 <= 37'(rho_s2) * 37'($signed({1'b0, uv_s2[17:0]}));
			uv_hi_s3 <= 37'(rho_s2) * 37'($signed(uv_s2[35:18]));
			ru_s3    <= 36'(rho_s2) * 36'(u_s2);
			rv_s3    <= 36'(rho_s2) * 36'(v_s2);
		end
	end

	// Recombine halves and round half up to Q14.
	always_comb begin
		p_full  = (56'(p_hi_s3) <<< 18) + 56'(p_lo_s3) + 56'sd134217728;
		df_full = (56'(df_hi_s3) <<< 18) + 56'(df_lo_s3) + 56'sd134217728;
		uv_full = (56'(uv_hi_s3) <<< 18) + 56'(uv_lo_s3) + 56'sd134217728;
		ru_rnd  = 37'(ru_s3) + 37'sd8192;
		rv_rnd  = 37'(rv_s3) + 37'sd8192;
	end

	// Stage 4: kinetic term, the first-order equilibrium moments and the stress equilibria.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s4    <= f_s3;
			m_s4    <= m_s3;
			rho_s4  <= rho_s3;
			p_s4    <= p_full[53:28];
			meq7_s4 <= df_full[53:28];
			meq8_s4 <= uv_full[53:28];
			meq3_s4 <= ru_rnd[36:14];
			meq5_s4 <= rv_rnd[36:14];
		end
	end

	// Stage 5: energy factors 3p - 2 and 1 - 3p in Q14.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s5    <= f_s4;
			m_s5    <= m_s4;
			rho_s5  <= rho_s4;
			meq3_s5 <= meq3_s4;
			meq5_s5 <= meq5_s4;
			meq7_s5 <= meq7_s4;
			meq8_s5 <= meq8_s4;
			t1_s5   <= (28'(p_s4) <<< 1) + 28'(p_s4) - 28'sd32768;
			t2_s5   <= 28'sd16384 - (28'(p_s4) <<< 1) - 28'(p_s4);
		end
	end

	// Stage 6: density times the energy factors.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s6    <= f_s5;
			m_s6    <= m_s5;
			rho_s6  <= rho_s5;
			meq3_s6 <= meq3_s5;
			meq5_s6 <= meq5_s5;
			meq7_s6 <= meq7_s5;
			meq8_s6 <= meq8_s5;
			e1_s6   <= 46'(rho_s5) * 46'(t1_s5);
			e2_s6   <= 46'(rho_s5) * 46'(t2_s5);
		end
	end

	// Non-equilibrium parts; the heat flux equilibria are the negated momenta.
	always_comb begin
		e1_rnd  = e1_s6 + 46'sd8192;
		e2_rnd  = e2_s6 + 46'sd8192;
		d_c[0]  = DW'(m_s6[0]) - DW'(rho_s6);
		d_c[1]  = DW'(m_s6[1]) - DW'($signed(e1_rnd[45:14]));
		d_c[2]  = DW'(m_s6[2]) - DW'($signed(e2_rnd[45:14]));
		d_c[3]  = DW'(m_s6[3]) - DW'(meq3_s6);
		d_c[4]  = DW'(m_s6[4]) + DW'(meq3_s6);
		d_c[5]  = DW'(m_s6[5]) - DW'(meq5_s6);
		d_c[6]  = DW'(m_s6[6]) + DW'(meq5_s6);
		d_c[7]  = DW'(m_s6[7]) - DW'(meq7_s6);
		d_c[8]  = DW'(m_s6[8]) - DW'(meq8_s6);
	end

	// Stage 7: differences.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s7 <= f_s6;
			d_s7 <= d_c;
		end
	end

	// Stage 8: one rate multiplier per moment.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s8 <= f_s7;
			for (int l = 0; l < ND; l++) begin
				r_s8[l] <= RW'(d_s7[l])
					* RW'($signed({1'b0, rate[lmc_pkg::RATE_OF_MOMENT[l]]}));
			end
		end
	end

	assign relax = r_s8;
	assign f_out = f_s8;

endmodule

>>> rtl/core/lmc_lane.sv
// ----------------------------------------------------------------------------
// lmc_lane: one output direction of the collision
// Applies one row of the scaled inverse transform, divides by 36 * 2^14
// with rounding and subtracts the correction from the distribution.
// ----------------------------------------------------------------------------
module lmc_lane #(
	parameter int unsigned LANE = 0
) (
	input  logic            clk,
	input  logic            en,
	input  lmc_pkg::relax_t relax [lmc_pkg::NUM_DIRS],
	input  lmc_pkg::q14_t   f,
	output logic signed [23:0] post_wide
);

	localparam int ND = lmc_pkg::NUM_DIRS;
	localparam int AW = lmc_pkg::ACC_W;
	localparam int QW = lmc_pkg::QUO_IN_W;
	localparam int PW = lmc_pkg::PROD_W;

	logic signed [AW-1:0] acc_c, acc_s9, acc_rnd;
	logic signed [39:0]   y_c, y_cl, n_c;
	logic [QW-1:0]        n_s10;
	logic [PW-1:0]        prod_s11;
	logic signed [22:0]   quo;
	lmc_pkg::q14_t        f_s9, f_s10, f_s11;
	logic signed [23:0]   r_s12;

	always_comb begin
		acc_c = '0;
		for (int l = 0; l < ND; l++) begin
			acc_c = acc_c + AW'(relax[l]) * AW'(lmc_pkg::INV_MAT[LANE][l]);
		end
	end

	// Dividing by 36 * 2^14 is a shift by 16 then a floor divide by nine. The
	// shifted value is clamped to 24 bits: past that the result saturates the
	// same way whatever the exact quotient.
	always_comb begin
		acc_rnd = acc_s9 + AW'(18 * 16384);
		y_c     = acc_rnd[55:16];
		if (y_c > 40'sd8388607) begin
			y_cl = 40'sd8388607;
		end else if (y_c < -40'sd8388608) begin
			y_cl = -40'sd8388608;
		end else begin
			y_cl = y_c;
		end
		n_c = y_cl + 40'(9 * lmc_pkg::DIV9_BIAS_Q);
	end

	always_comb begin
		quo = $signed({1'b0, prod_s11[PW-1:lmc_pkg::DIV9_SHIFT]})
			- 23'(lmc_pkg::DIV9_BIAS_Q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s9   <= acc_c;
			f_s9     <= f;
			n_s10    <= n_c[QW-1:0];
			f_s10    <= f_s9;
			prod_s11 <= PW'(n_s10) * PW'(lmc_pkg::DIV9_MULT);
			f_s11    <= f_s10;
			r_s12    <= 24'(f_s11) - 24'(quo);
		end
	end

	assign post_wide = r_s12;

endmodule
